FILE: hdl/sitoa_pkg.sv
// ----------------------------------------------------------------------------
// sitoa_pkg
// Shared types and character codes for the signed integer to decimal
// ASCII converter.
// ----------------------------------------------------------------------------
package sitoa_pkg;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_CONV  = 5'b00010,
    ST_SKIP  = 5'b00100,
    ST_SIGN  = 5'b01000,
    ST_DIGIT = 5'b10000
  } state_e;

endpackage

FILE: hdl/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii
// Prints one signed integer per input transfer as decimal ASCII text, one
// character per output transfer, with the last character flagged.
// ----------------------------------------------------------------------------
// A value is taken when in_valid_i and in_ready_o are high; the block then
// emits an optional '-' followed by the digits, most significant first, with
// no leading zeros (zero prints as "0"), and raises last_char_o on the final
// digit. The magnitude is turned into BCD by one shared shift-add-3 unit that
// takes one step per magnitude bit, then leading zero digits are dropped one
// per cycle and each character passes through the output register.
// in_ready_o is high only while the sequencer is idle; the last character
// may still wait in the output register while the next value is taken.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic        [7:0]            ascii_char_o,
  output logic                         last_char_o
);

  // decimal digits needed for a DATA_WIDTH-bit unsigned magnitude
  localparam int NumDigits = (DATA_WIDTH * 301) / 1000 + 1;
  localparam int BcdW      = NumDigits * 4;
  localparam int BitCntW   = $clog2(DATA_WIDTH + 1);
  localparam int DigCntW   = $clog2(NumDigits + 1);

  sitoa_pkg::state_e state_q, state_d;
  logic [BitCntW-1:0]    bit_cnt_q, bit_cnt_d;
  logic [DigCntW-1:0]    dig_cnt_q, dig_cnt_d;
  logic                  neg_q, neg_d;
  logic [DATA_WIDTH-1:0] mag_q, mag_d;
  logic [BcdW-1:0]       bcd_q, bcd_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            char_q, char_d;
  logic                  last_q, last_d;

  logic [DATA_WIDTH-1:0] raw;
  logic [BcdW-1:0]       bcd_adj;
  logic [BcdW-1:0]       bcd_shift;
  logic [3:0]            top_digit;
  logic                  slot_free;

  assign raw       = value_i;
  assign top_digit = bcd_q[BcdW-1 -: 4];
  assign slot_free = !out_valid_q || out_ready_i;

  // shared shift-add-3 step
  always_comb begin
    bcd_adj = bcd_q;
    for (int i = 0; i < NumDigits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end
    end
    bcd_shift = {bcd_adj[BcdW-2:0], mag_q[DATA_WIDTH-1]};
  end

  always_comb begin
    state_d     = state_q;
    bit_cnt_d   = bit_cnt_q;
    dig_cnt_d   = dig_cnt_q;
    neg_d       = neg_q;
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      sitoa_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          neg_d     = raw[DATA_WIDTH-1];
          mag_d     = raw[DATA_WIDTH-1] ? (~raw + DATA_WIDTH'(1)) : raw;
          bcd_d     = '0;
          bit_cnt_d = BitCntW'(DATA_WIDTH);
          state_d   = sitoa_pkg::ST_CONV;
        end
      end
      sitoa_pkg::ST_CONV: begin
        bcd_d     = bcd_shift;
        mag_d     = {mag_q[DATA_WIDTH-2:0], 1'b0};
        bit_cnt_d = bit_cnt_q - BitCntW'(1);
        if (bit_cnt_q == BitCntW'(1)) begin
          dig_cnt_d = DigCntW'(NumDigits);
          state_d   = sitoa_pkg::ST_SKIP;
        end
      end
      sitoa_pkg::ST_SKIP: begin
        // drop leading zero digits, keep at least one
        if (top_digit == 4'd0 && dig_cnt_q > DigCntW'(1)) begin
          bcd_d     = {bcd_q[BcdW-5:0], 4'd0};
          dig_cnt_d = dig_cnt_q - DigCntW'(1);
        end else if (neg_q) begin
          state_d = sitoa_pkg::ST_SIGN;
        end else begin
          state_d = sitoa_pkg::ST_DIGIT;
        end
      end
      sitoa_pkg::ST_SIGN: begin
        if (slot_free) begin
          char_d      = sitoa_pkg::CHAR_MINUS;
          last_d      = 1'b0;
          out_valid_d = 1'b1;
          state_d     = sitoa_pkg::ST_DIGIT;
        end
      end
      sitoa_pkg::ST_DIGIT: begin
        if (slot_free) begin
          char_d      = sitoa_pkg::CHAR_ZERO + {4'd0, top_digit};
          last_d      = (dig_cnt_q == DigCntW'(1));
          out_valid_d = 1'b1;
          bcd_d       = {bcd_q[BcdW-5:0], 4'd0};
          dig_cnt_d   = dig_cnt_q - DigCntW'(1);
          if (dig_cnt_q == DigCntW'(1)) begin
            state_d = sitoa_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = sitoa_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sitoa_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      bit_cnt_q   <= '0;
      dig_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      bit_cnt_q   <= bit_cnt_d;
      dig_cnt_q   <= dig_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q  <= neg_d;
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign in_ready_o   = (state_q == sitoa_pkg::ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = char_q;
  assign last_char_o  = last_q;

endmodule

FILE: hdl/sitoa_checker.sv
// ----------------------------------------------------------------------------
// sitoa_checker
// Port-level checks for the signed integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
module sitoa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] ascii_char_o,
  input logic       last_char_o
);

  // stalled output transfer holds its character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(ascii_char_o) && $stable(last_char_o))
    else $error("stalled output changed");

  // only a sign or a digit ever comes out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ascii_char_o == sitoa_pkg::CHAR_MINUS ||
      (ascii_char_o >= sitoa_pkg::CHAR_ZERO && ascii_char_o <= sitoa_pkg::CHAR_NINE))
    else $error("output character out of range");

  // a minus sign never ends the text
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ascii_char_o == sitoa_pkg::CHAR_MINUS |-> !last_char_o)
    else $error("minus sign flagged as last");

  // busy while converting an accepted value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after input transfer");

endmodule

bind signed_int_to_decimal_ascii sitoa_checker u_sitoa_checker (.*);

FILE: tb/signed_int_to_decimal_ascii_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test
// Sends signed 32-bit values into the converter and checks every character it
// prints, including the last-character flag, against a behavioral predictor
// and a short list of hand-written texts. Both channels stall at random.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;

  localparam int WIDTH        = 32;
  localparam int NUM_DIRECTED = 20;
  localparam int RANDOM_ITEMS = 140;
  localparam int CALM_ITEMS   = 30;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_char_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_ready_o;
  logic signed [WIDTH-1:0] value_i;
  logic                    out_valid_o;
  logic                    out_ready_i;
  logic [7:0]              ascii_char_o;
  logic                    last_char_o;

  text_char_t text_q[$];
  int         errors;
  int         values_sent;
  int         negatives_sent;
  int         chars_checked;
  bit         no_idle;
  bit         long_hold_req;

  // empty text means the predictor decides
  logic signed [WIDTH-1:0] vec_value[NUM_DIRECTED] = '{
    32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10, 32'sd99, 32'sd100,
    32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh8000_0001, 32'sd1000000000,
    32'sd999999999, -32'sd999999999, 32'sh5555_5555, 32'shAAAA_AAAA,
    32'sd12345, -32'sd5, -32'sd1000000000, 32'sd4096
  };
  string vec_text[NUM_DIRECTED] = '{
    "0", "1", "-1", "9", "10", "-10", "", "",
    "2147483647", "-2147483648", "-2147483647", "1000000000",
    "", "", "", "", "", "-5", "-1000000000", ""
  };

  signed_int_to_decimal_ascii #(
    .DATA_WIDTH(WIDTH)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ascii_char_o(ascii_char_o),
    .last_char_o (last_char_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // decimal text of a value: optional minus, digits msd first, last flagged
  task automatic predict_text(input logic signed [WIDTH-1:0] v);
    logic [WIDTH:0] mag;
    logic [7:0]     digits[$];
    text_char_t     c;
    mag = v[WIDTH-1] ? ({(WIDTH+1){1'b0}} - {v[WIDTH-1], v}) : {1'b0, v};
    do begin
      digits.push_front(sitoa_pkg::CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (v[WIDTH-1]) begin
      c.ch   = sitoa_pkg::CHAR_MINUS;
      c.last = 1'b0;
      text_q.push_back(c);
    end
    foreach (digits[i]) begin
      c.ch   = digits[i];
      c.last = (i == digits.size() - 1);
      text_q.push_back(c);
    end
  endtask

  task automatic offer_value(input logic signed [WIDTH-1:0] v, input string text);
    text_char_t c;
    in_valid_i <= 1'b1;
    value_i    <= v;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    values_sent++;
    if (v[WIDTH-1]) negatives_sent++;
    if (text.len() == 0) begin
      predict_text(v);
    end else begin
      for (int i = 0; i < text.len(); i++) begin
        c.ch   = text[i];
        c.last = (i == text.len() - 1);
        text_q.push_back(c);
      end
    end
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  initial begin : stimulus
    logic signed [WIDTH-1:0] v;
    longint                  lim;
    int                      k;
    errors        = 0;
    values_sent   = 0;
    negatives_sent = 0;
    chars_checked = 0;
    no_idle       = 1'b0;
    long_hold_req = 1'b0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    value_i       = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int n = 0; n < NUM_DIRECTED; n++) begin
      offer_value(vec_value[n], vec_text[n]);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= RANDOM_ITEMS - CALM_ITEMS);
      // receiver holds off while values keep coming, so the input backs up
      if (n == 40) long_hold_req = 1'b1;
      if (n == 80) begin
        in_valid_i <= 1'b0;
        wait (text_q.size() == 0);
        @(posedge clk_i);
      end
      case ($urandom_range(0, 4))
        0: v = $urandom;
        1: begin
          k   = $urandom_range(1, 10);
          lim = 1;
          repeat (k) lim = lim * 10;
          v = WIDTH'(longint'($urandom) % lim);
          if ($urandom_range(0, 1)) v = -v;
        end
        2: begin
          // just around a power of ten
          k   = $urandom_range(0, 9);
          lim = 1;
          repeat (k) lim = lim * 10;
          v = WIDTH'(lim) + $urandom_range(0, 2) - 1;
          if ($urandom_range(0, 1)) v = -v;
        end
        3: v = $urandom_range(0, 1) ? 32'sh7FFF_FFFF - $urandom_range(0, 3)
                                     : 32'sh8000_0000 + $urandom_range(0, 3);
        default: begin
          v = $urandom_range(0, 20);
          if ($urandom_range(0, 1)) v = -v;
        end
      endcase
      offer_value(v, "");
    end
    in_valid_i <= 1'b0;

    wait (text_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("converted %0d values (%0d negative), checked %0d characters",
             values_sent, negatives_sent, chars_checked);
    if (errors == 0 && text_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : receiver
    out_ready_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (long_hold_req) begin
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_req = 1'b0;
      end else if (!no_idle && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(0, 3) == 0 ? 40 : $urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin : char_check
    text_char_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      chars_checked++;
      if (text_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected character transfer, got char %h last %b",
                 $time, ascii_char_o, last_char_o);
      end else begin
        want = text_q.pop_front();
        if (ascii_char_o !== want.ch) begin
          errors++;
          $display("%0t: ascii_char expected %h got %h", $time, want.ch, ascii_char_o);
        end
        if (last_char_o !== want.last) begin
          errors++;
          $display("%0t: last_char expected %b got %b", $time, want.last, last_char_o);
        end
      end
    end
  end

  initial begin : watchdog
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: files.f
hdl/sitoa_pkg.sv
hdl/signed_int_to_decimal_ascii.sv
hdl/sitoa_checker.sv
tb/signed_int_to_decimal_ascii_test.sv
